>>> rtl/dcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcr_pkg: shared types and constants of the DCT coefficient requantizer
// Holds the payload structs, the target intra matrix, the quality scale
// table and the widths of the pipelined divider.
// ----------------------------------------------------------------------------
package dcr_pkg;

	localparam int BLOCK_ENTRIES = 64;
	localparam int NUM_W = 27;
	localparam int QUO_W = 17;
	localparam int DIV_W = 8;
	localparam int SCALE_W = 13;
	localparam int X_W = 18;
	localparam int DIV_STEPS = QUO_W;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_COEF = 1'b1;

	localparam logic [6:0] QUALITY_RESET = 7'd10;

	// Division by 100 through a reciprocal, exact for operands below 25600.
	localparam logic [X_W-1:0] DIVISOR_CLAMP_X = 18'd25600;
	localparam logic [15:0] RECIP_100 = 16'd41944;
	localparam int RECIP_SHIFT = 22;
	localparam logic [X_W-1:0] ROUND_BIAS = 18'd50;
	localparam logic [DIV_W-1:0] DIVISOR_MAX = 8'd255;
	localparam logic [DIV_W-1:0] DIVISOR_MIN = 8'd1;

	localparam logic [QUO_W-1:0] POS_LIMIT = 17'd32767;
	localparam logic [QUO_W-1:0] NEG_LIMIT = 17'd32768;

	localparam logic [5:0] INTRA_MATRIX [BLOCK_ENTRIES] = '{
		6'd8,  6'd17, 6'd18, 6'd19, 6'd21, 6'd23, 6'd25, 6'd27,
		6'd17, 6'd18, 6'd19, 6'd21, 6'd23, 6'd25, 6'd27, 6'd28,
		6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd26, 6'd28, 6'd30,
		6'd21, 6'd22, 6'd23, 6'd24, 6'd26, 6'd28, 6'd30, 6'd32,
		6'd22, 6'd23, 6'd24, 6'd26, 6'd28, 6'd30, 6'd32, 6'd35,
		6'd23, 6'd24, 6'd26, 6'd28, 6'd30, 6'd32, 6'd35, 6'd38,
		6'd25, 6'd26, 6'd28, 6'd30, 6'd32, 6'd35, 6'd38, 6'd41,
		6'd27, 6'd28, 6'd30, 6'd32, 6'd35, 6'd38, 6'd41, 6'd45
	};

	typedef struct packed {
		logic              req_type;
		logic [1:0]        table_select;
		logic [5:0]        coef_index;
		logic [15:0]       quant_entry;
		logic signed [11:0] coef_value;
	} req_t;

	typedef struct packed {
		logic signed [15:0] coef_out;
		logic               saturated;
	} rsp_t;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DIV_W-1:0] divisor;
		logic             neg;
	} div_in_t;

	typedef struct packed {
		logic [QUO_W-1:0] quo;
		logic             neg;
		logic             big;
	} div_out_t;

	// Scale of the target matrix; quality 0 acts as 1 and above 100 as 100.
	function automatic logic [SCALE_W-1:0] scale_of(input logic [6:0] q);
		logic [SCALE_W-1:0] s;
		s = '0;
		priority if (q == 7'd0) begin
			s = 13'd5000;
		end else if (q >= 7'd100) begin
			s = 13'd0;
		end else if (q >= 7'd50) begin
			s = 13'd200 - {5'd0, q, 1'b0};
		end else begin
			unique case (q)
				7'd1:  s = 13'd5000;
				7'd2:  s = 13'd2500;
				7'd3:  s = 13'd1666;
				7'd4:  s = 13'd1250;
				7'd5:  s = 13'd1000;
				7'd6:  s = 13'd833;
				7'd7:  s = 13'd714;
				7'd8:  s = 13'd625;
				7'd9:  s = 13'd555;
				7'd10: s = 13'd500;
				7'd11: s = 13'd454;
				7'd12: s = 13'd416;
				7'd13: s = 13'd384;
				7'd14: s = 13'd357;
				7'd15: s = 13'd333;
				7'd16: s = 13'd312;
				7'd17: s = 13'd294;
				7'd18: s = 13'd277;
				7'd19: s = 13'd263;
				7'd20: s = 13'd250;
				7'd21: s = 13'd238;
				7'd22: s = 13'd227;
				7'd23: s = 13'd217;
				7'd24: s = 13'd208;
				7'd25: s = 13'd200;
				7'd26: s = 13'd192;
				7'd27: s = 13'd185;
				7'd28: s = 13'd178;
				7'd29: s = 13'd172;
				7'd30: s = 13'd166;
				7'd31: s = 13'd161;
				7'd32: s = 13'd156;
				7'd33: s = 13'd151;
				7'd34: s = 13'd147;
				7'd35: s = 13'd142;
				7'd36: s = 13'd138;
				7'd37: s = 13'd135;
				7'd38: s = 13'd131;
				7'd39: s = 13'd128;
				7'd40: s = 13'd125;
				7'd41: s = 13'd121;
				7'd42: s = 13'd119;
				7'd43: s = 13'd116;
				7'd44: s = 13'd113;
				7'd45: s = 13'd111;
				7'd46: s = 13'd108;
				7'd47: s = 13'd106;
				7'd48: s = 13'd104;
				7'd49: s = 13'd102;
				default: s = 13'd0;
			endcase
		end
		return s;
	endfunction

endpackage

>>> rtl/dcr_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcr_divider: pipelined restoring divider
// Produces one quotient bit per stage, most significant first, with its own
// valid and ready chain so that bubbles collapse under a stall.
// ----------------------------------------------------------------------------
module dcr_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dcr_pkg::div_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output dcr_pkg::div_out_t out_data
);
	import dcr_pkg::*;

	logic             dv_s   [DIV_STEPS];
	logic             rdy    [DIV_STEPS];
	logic [NUM_W-1:0] rem_s  [DIV_STEPS];
	logic [QUO_W-1:0] quo_s  [DIV_STEPS];
	logic [DIV_W-1:0] dvs_s  [DIV_STEPS];
	logic             neg_s  [DIV_STEPS];
	logic             big_s  [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
		localparam int BIT = DIV_STEPS - 1 - k;
		logic             v_in;
		logic [NUM_W-1:0] rem_in;
		logic [QUO_W-1:0] quo_in;
		logic [DIV_W-1:0] d_in;
		logic             neg_in;
		logic             big_in;
		logic             rdy_next;
		logic [NUM_W-1:0] sub_val;
		logic             ge;

		if (k == 0) begin : g_first
			assign v_in   = in_valid;
			assign rem_in = in_data.num;
			assign quo_in = '0;
			assign d_in   = in_data.divisor;
			assign neg_in = in_data.neg;
			// A quotient too wide for the stages always saturates.
			assign big_in = in_data.num >= (NUM_W'(in_data.divisor) << QUO_W);
		end else begin : g_next
			assign v_in   = dv_s[k-1];
			assign rem_in = rem_s[k-1];
			assign quo_in = quo_s[k-1];
			assign d_in   = dvs_s[k-1];
			assign neg_in = neg_s[k-1];
			assign big_in = big_s[k-1];
		end

		if (k == DIV_STEPS - 1) begin : g_last
			assign rdy_next = out_ready;
		end else begin : g_mid
			assign rdy_next = rdy[k+1];
		end

		assign rdy[k]  = !dv_s[k] || rdy_next;
		assign sub_val = NUM_W'(d_in) << BIT;
		assign ge      = rem_in >= sub_val;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				dv_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				rem_s[k] <= ge ? rem_in - sub_val : rem_in;
				quo_s[k] <= quo_in | (QUO_W'(ge) << BIT);
				dvs_s[k] <= d_in;
				neg_s[k] <= neg_in;
				big_s[k] <= big_in;
			end
		end
	end

	assign in_ready      = rdy[0];
	assign out_valid     = dv_s[DIV_STEPS-1];
	assign out_data.quo  = quo_s[DIV_STEPS-1];
	assign out_data.neg  = neg_s[DIV_STEPS-1];
	assign out_data.big  = big_s[DIV_STEPS-1];

endmodule

>>> rtl/dct_coefficient_requantizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct_coefficient_requantizer_core: DCT coefficient requantizer
// Pipeline: a coefficient transfer passes through four front stages,
// seventeen divider stages and one output register.
// Throughput: one item per cycle unless the output stalls.
// Reset clears all valid bits and sets quality 10; old tables are undefined
// until loaded.
// ----------------------------------------------------------------------------
module dct_coefficient_requantizer_core #(
	parameter int NUM_TABLES = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [6:0]    cfg_quality,
	input  logic          req_valid,
	output logic          req_ready,
	input  dcr_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output dcr_pkg::rsp_t rsp
);
	import dcr_pkg::*;

	localparam int DEPTH  = NUM_TABLES * BLOCK_ENTRIES;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [SCALE_W-1:0] scale_q;

	logic [15:0]       mem [DEPTH];
	logic [ADDR_W-1:0] addr;
	logic              present;
	logic              req_fire;
	logic [11:0]       raw;

	logic en1, en2, en3, en4;

	logic              v_s1, neg_s1, present_s1;
	logic [11:0]       mag_s1;
	logic [5:0]        pos_s1;
	logic [15:0]       oldq_s1;

	logic              v_s2, neg_s2;
	logic [X_W-1:0]    x_s2;
	logic [NUM_W-1:0]  prod_s2;
	logic [X_W:0]      mx;

	logic              v_s3, neg_s3, hi_s3;
	logic [30:0]       t_s3;
	logic [NUM_W-1:0]  prod_s3;

	logic              v_s4, neg_s4;
	logic [DIV_W-1:0]  d_s4;
	logic [NUM_W-1:0]  num_s4;
	logic [DIV_W-1:0]  d_raw, d_sel;

	logic              div_ready, div_valid;
	div_in_t           div_in;
	div_out_t          div_out;

	logic              en_out, over;
	logic [QUO_W-1:0]  limit, res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= scale_of(QUALITY_RESET);
		end else if (cfg_valid && cfg_ready) begin
			scale_q <= scale_of(cfg_quality);
		end
	end

	assign req_ready = en1;
	assign req_fire  = req_valid && req_ready;
	assign addr      = ADDR_W'({req.table_select, req.coef_index});
	assign present   = {1'b0, req.table_select} < 3'(NUM_TABLES);
	assign raw       = req.coef_value;

	assign en1 = !v_s1 || en2;
	assign en2 = !v_s2 || en3;
	assign en3 = !v_s3 || en4;
	assign en4 = !v_s4 || div_ready;

	always_ff @(posedge clk) begin
		if (req_fire && req.req_type == REQ_LOAD && present) begin
			mem[addr] <= req.quant_entry;
		end
		if (en1) begin
			oldq_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= req_fire && req.req_type == REQ_COEF;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	assign mx = (X_W+1)'(INTRA_MATRIX[pos_s1]) * (X_W+1)'(scale_q);

	assign d_raw = t_s3[RECIP_SHIFT+DIV_W-1:RECIP_SHIFT];
	always_comb begin
		if (hi_s3) begin
			d_sel = DIVISOR_MAX;
		end else if (d_raw == '0) begin
			d_sel = DIVISOR_MIN;
		end else begin
			d_sel = d_raw;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			neg_s1     <= raw[11];
			mag_s1     <= raw[11] ? (~raw + 12'd1) : raw;
			pos_s1     <= req.coef_index;
			present_s1 <= present;
		end
		if (en2) begin
			neg_s2  <= neg_s1;
			x_s2    <= X_W'(mx) + ROUND_BIAS;
			prod_s2 <= NUM_W'(mag_s1) * NUM_W'(present_s1 ? oldq_s1 : 16'd0);
		end
		if (en3) begin
			neg_s3  <= neg_s2;
			hi_s3   <= x_s2 >= DIVISOR_CLAMP_X;
			t_s3    <= 31'(x_s2[14:0]) * 31'(RECIP_100);
			prod_s3 <= prod_s2;
		end
		if (en4) begin
			neg_s4 <= neg_s3;
			d_s4   <= d_sel;
			num_s4 <= prod_s3 + NUM_W'(d_sel >> 1);
		end
	end

	assign div_in.num     = num_s4;
	assign div_in.divisor = d_s4;
	assign div_in.neg     = neg_s4;

	dcr_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_ready  (div_ready),
		.in_data   (div_in),
		.out_valid (div_valid),
		.out_ready (en_out),
		.out_data  (div_out)
	);

	assign en_out = !rsp_valid || rsp_ready;
	assign limit  = div_out.neg ? NEG_LIMIT : POS_LIMIT;
	assign over   = div_out.big || (div_out.quo > limit);
	assign res    = over ? limit : div_out.quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (en_out) begin
			rsp_valid <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			rsp.coef_out  <= div_out.neg ? signed'(16'd0 - res[15:0]) : signed'(res[15:0]);
			rsp.saturated <= over;
		end
	end

endmodule
